### hdl/tfrp_pkg.sv
package tfrp_pkg;

    // Default values of the top-level parameters.
    localparam int ANGLE_FRAC_BITS_DEF = 12;
    localparam int CORDIC_STEPS_DEF    = 16;

    // Field widths.
    localparam int SAMPLE_W = 14;
    localparam int AVG_W    = 14;
    localparam int ROLL_W   = 16;
    localparam int PITCH_W  = 14;
    localparam int GAIN_W   = 16;

    localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd328;

    // Configuration register map (byte addresses).
    localparam int               PADDR_W          = 3;
    localparam logic [PADDR_W-1:0] ADDR_FILTER_GAIN = 3'd0;

    // Multiplier operand and product widths.
    localparam int MUL_A_W = 15;
    localparam int MUL_B_W = 18;
    localparam int MUL_P_W = 33;

    // Square root: radicand is (x^2 + y^2) * 2^16.
    localparam int SUMSQ_W  = 28;
    localparam int SQ_IN_W  = 44;
    localparam int SQ_OUT_W = 22;

    // Vectoring CORDIC datapath.
    localparam int CIN_W       = 23;
    localparam int CORDIC_W    = 45;
    localparam int PRESCALE_SH = 20;
    localparam int ANG_W       = 35;
    localparam int ATAN_IDX_W  = 5;
    localparam int ATAN_W      = 30;

    localparam logic signed [ANG_W-1:0] PI_Q30          = 35'sd3373259426;
    localparam logic signed [ANG_W-1:0] HALF_PI_Q30     = 35'sd1686629713;
    localparam logic signed [ANG_W-1:0] THREE_HALF_PI_Q30 = 35'sd5059889139;

    // Request to the CORDIC unit: a start strobe and the vector (x, y).
    typedef struct packed {
        logic             start;
        logic [CIN_W-1:0] x;
        logic [CIN_W-1:0] y;
    } t_cordic_req;

    // Elementary angles atan(2^-i) in Q30.
    function automatic logic [ATAN_W-1:0] atan_q30(input logic [ATAN_IDX_W-1:0] idx);
        logic [ATAN_W-1:0] v;
        case (idx)
            5'd0:    v = 30'h3243F6A8;
            5'd1:    v = 30'h1DAC6705;
            5'd2:    v = 30'h0FADBAFC;
            5'd3:    v = 30'h07F56EA6;
            5'd4:    v = 30'h03FEAB76;
            5'd5:    v = 30'h01FFD55B;
            5'd6:    v = 30'h00FFFAAA;
            5'd7:    v = 30'h007FFF55;
            5'd8:    v = 30'h003FFFEA;
            5'd9:    v = 30'h001FFFFD;
            5'd10:   v = 30'h000FFFFF;
            5'd11:   v = 30'h0007FFFF;
            5'd12:   v = 30'h0003FFFF;
            5'd13:   v = 30'h0001FFFF;
            5'd14:   v = 30'h0000FFFF;
            5'd15:   v = 30'h00007FFF;
            5'd16:   v = 30'h00003FFF;
            5'd17:   v = 30'h00001FFF;
            5'd18:   v = 30'h00000FFF;
            5'd19:   v = 30'h000007FF;
            5'd20:   v = 30'h000003FF;
            5'd21:   v = 30'h000001FF;
            5'd22:   v = 30'h000000FF;
            5'd23:   v = 30'h0000007F;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

### hdl/tfrp_if.sv
interface tfrp_in_if;
    logic                            valid;
    logic                            ready;
    logic [tfrp_pkg::SAMPLE_W-1:0]   sample_x;
    logic [tfrp_pkg::SAMPLE_W-1:0]   sample_y;
    logic [tfrp_pkg::SAMPLE_W-1:0]   sample_z;

    modport source (output valid, sample_x, sample_y, sample_z, input ready);
    modport sink   (input valid, sample_x, sample_y, sample_z, output ready);
endinterface

interface tfrp_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [tfrp_pkg::ROLL_W-1:0]  roll_angle;
    logic signed [tfrp_pkg::PITCH_W-1:0] pitch_angle;
    logic signed [tfrp_pkg::AVG_W-1:0]   smoothed_x;
    logic signed [tfrp_pkg::AVG_W-1:0]   smoothed_y;
    logic signed [tfrp_pkg::AVG_W-1:0]   smoothed_z;

    modport source (output valid, roll_angle, pitch_angle, smoothed_x, smoothed_y,
                    smoothed_z, input ready);
    modport sink   (input valid, roll_angle, pitch_angle, smoothed_x, smoothed_y,
                    smoothed_z, output ready);
endinterface

### hdl/tilt_filter_roll_pitch_core.sv
// Tilt filter: roll and pitch angles from a three-axis accelerometer.
//
// Input channel i_in_word carries one word of three raw 14-bit ADC samples.
// Each sample is centred, smoothed by an exponential moving average whose
// gain is the filter_gain register (Q0.16, byte address 0 on the APB-style
// port), and the smoothed vector is turned into roll and pitch in radians
// scaled by 2^ANGLE_FRAC_BITS. Output channel o_out_word carries one word per
// input word: both angles and the three smoothed components.
//
// The block takes one word at a time. After acceptance the moving average
// runs a multiply state and an accumulate state for each axis on the shared
// multiplier, which then squares the smoothed x and y; the root of their sum
// runs beside the roll rotation, then the pitch rotation follows on the same
// CORDIC unit, which a pitch vector lying on an axis skips. Input is ready
// again in the same cycle as the result is offered, so a new word is taken
// only after the last result has been offered. If the receiver stalls, the
// next result waits in the sequencer until the output register is free.
// Reset clears the averages, restores the default gain and empties the
// output register. pready is always high.
module tilt_filter_roll_pitch_core #(
    parameter int ANGLE_FRAC_BITS = tfrp_pkg::ANGLE_FRAC_BITS_DEF,
    parameter int CORDIC_STEPS    = tfrp_pkg::CORDIC_STEPS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    tfrp_in_if.sink                         i_in_word,
    tfrp_out_if.source                      o_out_word,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tfrp_pkg::PADDR_W-1:0]    paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    localparam int AVG_W  = tfrp_pkg::AVG_W;
    localparam int AW     = tfrp_pkg::ANG_W;
    localparam int RND_W  = AW + 5;
    localparam int RND_SH = 30 - ANGLE_FRAC_BITS;
    localparam logic signed [RND_W-1:0] RND_HALF = RND_W'(1) <<< (RND_SH - 1);

    // Sequencer states.
    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_EMA_MUL   = 4'd1;
    localparam logic [3:0] S_EMA_ACC   = 4'd2;
    localparam logic [3:0] S_SQ_X      = 4'd3;
    localparam logic [3:0] S_SQ_Y      = 4'd4;
    localparam logic [3:0] S_SQ_ACC    = 4'd5;
    localparam logic [3:0] S_START     = 4'd6;
    localparam logic [3:0] S_RUN       = 4'd7;
    localparam logic [3:0] S_PITCH     = 4'd8;
    localparam logic [3:0] S_PITCH_RUN = 4'd9;
    localparam logic [3:0] S_OUT       = 4'd10;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    logic [3:0]                        r_state;
    logic [3:0]                        n_state;
    logic [1:0]                        r_axis;
    logic [tfrp_pkg::GAIN_W-1:0]       r_gain;

    logic signed [AVG_W-1:0]           r_s_x, r_s_y, r_s_z;
    logic signed [AVG_W-1:0]           r_avg_x, r_avg_y, r_avg_z;
    logic [tfrp_pkg::SUMSQ_W-1:0]      r_sumsq;
    logic signed [AW-1:0]              r_roll;

    logic                              r_out_valid;
    logic signed [tfrp_pkg::ROLL_W-1:0]  r_out_roll;
    logic signed [tfrp_pkg::PITCH_W-1:0] r_out_pitch;
    logic signed [AVG_W-1:0]           r_out_x, r_out_y, r_out_z;

    logic                              w_cfg_wr;
    logic                              w_accept;
    logic                              w_out_free;

    logic signed [AVG_W-1:0]           w_s_sel;
    logic signed [AVG_W-1:0]           w_avg_sel;
    logic signed [AVG_W-1:0]           w_sq_sel;
    logic signed [tfrp_pkg::MUL_A_W-1:0] w_mul_a;
    logic signed [tfrp_pkg::MUL_B_W-1:0] w_mul_b;
    logic signed [tfrp_pkg::MUL_P_W-1:0] w_prod;
    logic signed [31:0]                w_num;
    logic signed [31:0]                w_num_adj;
    logic signed [31:0]                w_quot;
    logic signed [AVG_W-1:0]           w_avg_new;

    logic                              w_sqrt_busy;
    logic [tfrp_pkg::SQ_OUT_W-1:0]     w_mag;
    tfrp_pkg::t_cordic_req             w_req;
    logic                              w_cordic_busy;
    logic signed [AW-1:0]              w_angle;

    logic signed [AW-1:0]              w_remap;
    logic signed [AW-1:0]              w_roll_fix;
    logic signed [RND_W-1:0]           w_roll_sum;
    logic signed [RND_W-1:0]           w_roll_rnd;
    logic signed [RND_W-1:0]           w_pitch_sum;
    logic signed [RND_W-1:0]           w_pitch_rnd;

    // ---------------------------------------------------------------
    // Configuration port. Writes go to filter_gain only at address 0.
    // ---------------------------------------------------------------
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && (paddr == tfrp_pkg::ADDR_FILTER_GAIN);
    assign prdata   = (paddr == tfrp_pkg::ADDR_FILTER_GAIN) ? {16'h0000, r_gain} : 32'h0;

    // ---------------------------------------------------------------
    // Handshakes.
    // ---------------------------------------------------------------
    assign i_in_word.ready = (r_state == S_IDLE);
    assign w_accept        = i_in_word.valid && (r_state == S_IDLE);
    assign w_out_free      = !r_out_valid || o_out_word.ready;

    // ---------------------------------------------------------------
    // Shared multiplier. During the moving average it forms (s - avg) * g,
    // since avg' = trunc0((avg * 2^16 + (s - avg) * g) / 2^16); afterwards
    // it squares the smoothed x and y for the pitch magnitude.
    // ---------------------------------------------------------------
    always_comb begin
        case (r_axis)
            AXIS_X: begin
                w_s_sel   = r_s_x;
                w_avg_sel = r_avg_x;
            end
            AXIS_Y: begin
                w_s_sel   = r_s_y;
                w_avg_sel = r_avg_y;
            end
            default: begin
                w_s_sel   = r_s_z;
                w_avg_sel = r_avg_z;
            end
        endcase

        w_sq_sel = (r_state == S_SQ_Y) ? r_avg_y : r_avg_x;

        if (r_state == S_EMA_MUL) begin
            w_mul_a = $signed({w_s_sel[AVG_W-1], w_s_sel})
                    - $signed({w_avg_sel[AVG_W-1], w_avg_sel});
            w_mul_b = $signed({2'b00, r_gain});
        end else begin
            w_mul_a = $signed({w_sq_sel[AVG_W-1], w_sq_sel});
            w_mul_b = $signed({{(tfrp_pkg::MUL_B_W-AVG_W){w_sq_sel[AVG_W-1]}}, w_sq_sel});
        end

        // Division by 2^16 truncating toward zero: bias negative values first.
        w_num     = $signed({{2{w_avg_sel[AVG_W-1]}}, w_avg_sel, 16'h0000}) + w_prod[31:0];
        w_num_adj = w_num + (w_num[31] ? 32'sd65535 : 32'sd0);
        w_quot    = w_num_adj >>> 16;
        w_avg_new = w_quot[AVG_W-1:0];
    end

    tfrp_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    // ---------------------------------------------------------------
    // Square root of (x^2 + y^2) * 2^16, giving the magnitude in Q8.
    // ---------------------------------------------------------------
    tfrp_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_START),
        .i_value ({r_sumsq, 16'h0000}),
        .o_busy  (w_sqrt_busy),
        .o_root  (w_mag)
    );

    // ---------------------------------------------------------------
    // CORDIC, shared by roll atan2(-y, x) and pitch atan2(z * 2^8, mag).
    // ---------------------------------------------------------------
    always_comb begin
        w_req.start = (r_state == S_START) || (r_state == S_PITCH);
        if (r_state == S_PITCH) begin
            w_req.x = {1'b0, w_mag};
            w_req.y = {r_avg_z[AVG_W-1], r_avg_z, 8'h00};
        end else begin
            w_req.x = {{(tfrp_pkg::CIN_W-AVG_W){r_avg_x[AVG_W-1]}}, r_avg_x};
            w_req.y = -{{(tfrp_pkg::CIN_W-AVG_W){r_avg_y[AVG_W-1]}}, r_avg_y};
        end
    end

    tfrp_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_busy  (w_cordic_busy),
        .o_angle (w_angle)
    );

    // ---------------------------------------------------------------
    // Roll remap. The upper quadrant [pi/2, pi] folds to pi/2 - a, every
    // other non-zero angle moves up by 3pi/2, and whatever then lands in
    // (-pi/2, 0) is mirrored to positive.
    // ---------------------------------------------------------------
    always_comb begin
        if (w_angle >= tfrp_pkg::HALF_PI_Q30 && w_angle <= tfrp_pkg::PI_Q30) begin
            w_remap = tfrp_pkg::HALF_PI_Q30 - w_angle;
        end else if (w_angle != '0) begin
            w_remap = tfrp_pkg::THREE_HALF_PI_Q30 + w_angle;
        end else begin
            w_remap = '0;
        end
        if (w_remap > -tfrp_pkg::HALF_PI_Q30 && w_remap < 0) begin
            w_roll_fix = -w_remap;
        end else begin
            w_roll_fix = w_remap;
        end

        // Round half up from Q30 to the output fraction width.
        w_roll_sum  = $signed({{(RND_W-AW){r_roll[AW-1]}}, r_roll}) + RND_HALF;
        w_roll_rnd  = w_roll_sum >>> RND_SH;
        w_pitch_sum = $signed({{(RND_W-AW){w_angle[AW-1]}}, w_angle}) + RND_HALF;
        w_pitch_rnd = w_pitch_sum >>> RND_SH;
    end

    // ---------------------------------------------------------------
    // Sequencer.
    // ---------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_EMA_MUL;
                end
            end
            S_EMA_MUL:   n_state = S_EMA_ACC;
            S_EMA_ACC:   n_state = (r_axis == AXIS_Z) ? S_SQ_X : S_EMA_MUL;
            S_SQ_X:      n_state = S_SQ_Y;
            S_SQ_Y:      n_state = S_SQ_ACC;
            S_SQ_ACC:    n_state = S_START;
            S_START:     n_state = S_RUN;
            S_RUN: begin
                if (!w_sqrt_busy && !w_cordic_busy) begin
                    n_state = S_PITCH;
                end
            end
            S_PITCH:     n_state = S_PITCH_RUN;
            S_PITCH_RUN: begin
                if (!w_cordic_busy) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:     n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_axis      <= AXIS_X;
            r_gain      <= tfrp_pkg::GAIN_RESET;
            r_avg_x     <= '0;
            r_avg_y     <= '0;
            r_avg_z     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (w_cfg_wr) begin
                r_gain <= pwdata[tfrp_pkg::GAIN_W-1:0];
            end

            // Centring by 8192 is an inversion of the sample's top bit.
            if (w_accept) begin
                r_s_x  <= $signed({~i_in_word.sample_x[13], i_in_word.sample_x[12:0]});
                r_s_y  <= $signed({~i_in_word.sample_y[13], i_in_word.sample_y[12:0]});
                r_s_z  <= $signed({~i_in_word.sample_z[13], i_in_word.sample_z[12:0]});
                r_axis <= AXIS_X;
            end

            if (r_state == S_EMA_ACC) begin
                case (r_axis)
                    AXIS_X:  r_avg_x <= w_avg_new;
                    AXIS_Y:  r_avg_y <= w_avg_new;
                    default: r_avg_z <= w_avg_new;
                endcase
                r_axis <= r_axis + 2'd1;
            end

            if (r_state == S_SQ_Y) begin
                r_sumsq <= w_prod[tfrp_pkg::SUMSQ_W-1:0];
            end
            if (r_state == S_SQ_ACC) begin
                r_sumsq <= r_sumsq + w_prod[tfrp_pkg::SUMSQ_W-1:0];
            end

            if (r_state == S_RUN && !w_sqrt_busy && !w_cordic_busy) begin
                r_roll <= w_roll_fix;
            end

            // A new result replaces the one being taken; otherwise a taken
            // result empties the register.
            if (r_state == S_OUT && w_out_free) begin
                r_out_valid <= 1'b1;
                r_out_roll  <= w_roll_rnd[tfrp_pkg::ROLL_W-1:0];
                r_out_pitch <= w_pitch_rnd[tfrp_pkg::PITCH_W-1:0];
                r_out_x     <= r_avg_x;
                r_out_y     <= r_avg_y;
                r_out_z     <= r_avg_z;
            end else if (o_out_word.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_word.valid       = r_out_valid;
    assign o_out_word.roll_angle  = r_out_roll;
    assign o_out_word.pitch_angle = r_out_pitch;
    assign o_out_word.smoothed_x  = r_out_x;
    assign o_out_word.smoothed_y  = r_out_y;
    assign o_out_word.smoothed_z  = r_out_z;

endmodule

### hdl/tfrp_mul.sv
module tfrp_mul (
    input  logic                                 i_clk,
    input  logic signed [tfrp_pkg::MUL_A_W-1:0]  i_a,
    input  logic signed [tfrp_pkg::MUL_B_W-1:0]  i_b,
    output logic signed [tfrp_pkg::MUL_P_W-1:0]  o_prod
);

    logic signed [tfrp_pkg::MUL_P_W-1:0] r_prod;

    // The product is registered; it is valid in the cycle after the operands.
    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule

### hdl/tfrp_sqrt.sv
module tfrp_sqrt (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [tfrp_pkg::SQ_IN_W-1:0]     i_value,
    output logic                             o_busy,
    output logic [tfrp_pkg::SQ_OUT_W-1:0]    o_root
);

    localparam int W = tfrp_pkg::SQ_IN_W;
    localparam logic [W-1:0] BIT_INIT = {2'b01, {(W-2){1'b0}}};

    logic         r_busy;
    logic [W-1:0] r_rem;
    logic [W-1:0] r_res;
    logic [W-1:0] r_bit;
    logic [W:0]   w_trial;
    logic         w_fit;

    // One result bit per cycle: try to take (res + bit) out of the remainder.
    always_comb begin
        w_trial = {1'b0, r_res} + {1'b0, r_bit};
        w_fit   = ({1'b0, r_rem} >= w_trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_rem  <= i_value;
            r_res  <= '0;
            r_bit  <= BIT_INIT;
        end else if (r_busy) begin
            if (w_fit) begin
                r_rem <= r_rem - w_trial[W-1:0];
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
            if (r_bit[0]) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_root = r_res[tfrp_pkg::SQ_OUT_W-1:0];

endmodule

### hdl/tfrp_cordic.sv
module tfrp_cordic #(
    parameter int CORDIC_STEPS = tfrp_pkg::CORDIC_STEPS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  tfrp_pkg::t_cordic_req             i_req,
    output logic                              o_busy,
    output logic signed [tfrp_pkg::ANG_W-1:0] o_angle
);

    localparam int CIN_W  = tfrp_pkg::CIN_W;
    localparam int CW     = tfrp_pkg::CORDIC_W;
    localparam int AW     = tfrp_pkg::ANG_W;
    localparam int STEP_W = $clog2(CORDIC_STEPS);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS - 1);

    logic                    r_busy;
    logic [STEP_W-1:0]       r_step;
    logic signed [CW-1:0]    r_x;
    logic signed [CW-1:0]    r_y;
    logic signed [AW-1:0]    r_z;

    logic signed [CIN_W-1:0] w_x_in;
    logic signed [CIN_W-1:0] w_y_in;
    logic signed [CIN_W-1:0] w_x_abs;
    logic signed [CIN_W-1:0] w_y_abs;
    logic signed [AW-1:0]    w_off;
    logic signed [CW-1:0]    w_x_load;
    logic signed [CW-1:0]    w_y_load;
    logic signed [CW-1:0]    w_xs;
    logic signed [CW-1:0]    w_ys;
    logic signed [AW-1:0]    w_atan;
    logic                    w_y_pos;

    always_comb begin
        w_x_in = $signed(i_req.x);
        w_y_in = $signed(i_req.y);
        // A vector in the left half-plane is turned by pi before rotation.
        if (w_x_in[CIN_W-1]) begin
            w_x_abs = -w_x_in;
            w_y_abs = -w_y_in;
            w_off   = w_y_in[CIN_W-1] ? -tfrp_pkg::PI_Q30 : tfrp_pkg::PI_Q30;
        end else begin
            w_x_abs = w_x_in;
            w_y_abs = w_y_in;
            w_off   = '0;
        end
        w_x_load = $signed({{(CW-CIN_W){w_x_abs[CIN_W-1]}}, w_x_abs}) <<< tfrp_pkg::PRESCALE_SH;
        w_y_load = $signed({{(CW-CIN_W){w_y_abs[CIN_W-1]}}, w_y_abs}) <<< tfrp_pkg::PRESCALE_SH;

        w_xs    = r_x >>> r_step;
        w_ys    = r_y >>> r_step;
        w_atan  = $signed({{(AW-tfrp_pkg::ATAN_W){1'b0}},
                           tfrp_pkg::atan_q30(tfrp_pkg::ATAN_IDX_W'(r_step))});
        w_y_pos = !r_y[CW-1] && (r_y != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_req.start) begin
            // Vectors on an axis are answered at once without rotation.
            if (w_y_in == '0) begin
                r_z <= w_x_in[CIN_W-1] ? tfrp_pkg::PI_Q30 : '0;
            end else if (w_x_in == '0) begin
                r_z <= w_y_in[CIN_W-1] ? -tfrp_pkg::HALF_PI_Q30 : tfrp_pkg::HALF_PI_Q30;
            end else begin
                r_busy <= 1'b1;
                r_step <= '0;
                r_x    <= w_x_load;
                r_y    <= w_y_load;
                r_z    <= w_off;
            end
        end else if (r_busy) begin
            if (w_y_pos) begin
                r_x <= r_x + w_ys;
                r_y <= r_y - w_xs;
                r_z <= r_z + w_atan;
            end else begin
                r_x <= r_x - w_ys;
                r_y <= r_y + w_xs;
                r_z <= r_z - w_atan;
            end
            r_step <= r_step + 1'b1;
            if (r_step == LAST_STEP) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy  = r_busy;
    assign o_angle = r_z;

endmodule

### test/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Three-axis sample words go in on one channel. Roll, pitch and the three
    // smoothed components come back on the other. A predictor keeps its own
    // copy of the moving averages and of the gain register. For each word that
    // the block accepts, it works out the result word bit for bit and queues
    // it. A checking process compares every result word, field by field, with
    // the oldest queued prediction. Inputs change on the falling clock edge and
    // outputs are sampled on the rising edge.

    localparam int FRAC  = tfrp_pkg::ANGLE_FRAC_BITS_DEF;
    localparam int STEPS = tfrp_pkg::CORDIC_STEPS_DEF;

    localparam int CENTRE   = 8192;
    localparam int GAIN_ONE = 65536;
    localparam int RAW_MAX  = 16383;

    localparam longint PI_ANG      = 64'sd3373259426;
    localparam longint HALF_PI_ANG = 64'sd1686629713;
    localparam longint VEC_SCALE   = 64'sd1048576;

    // Cycles without any word moving before the run is declared hung. The
    // longest correct stretch is the deliberate hold-off on the output side.
    localparam int WATCHDOG_LIMIT = 4000;
    // Cycles allowed for the block to settle once the last result is in.
    localparam int SETTLE_CYCLES  = 64;
    // Length of the long receiver hold-off, in cycles.
    localparam int LONG_HOLD      = 800;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idle_mode;

    typedef struct packed {
        logic signed [tfrp_pkg::ROLL_W-1:0]  roll;
        logic signed [tfrp_pkg::PITCH_W-1:0] pitch;
        logic signed [tfrp_pkg::AVG_W-1:0]   sx;
        logic signed [tfrp_pkg::AVG_W-1:0]   sy;
        logic signed [tfrp_pkg::AVG_W-1:0]   sz;
    } t_tilt_word;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [tfrp_pkg::PADDR_W-1:0]  paddr;
    logic [31:0]                   pwdata;
    logic [31:0]                   prdata;
    logic                          pready;

    tfrp_in_if  u_in ();
    tfrp_out_if u_out ();

    tilt_filter_roll_pitch_core #(
        .ANGLE_FRAC_BITS (FRAC),
        .CORDIC_STEPS    (STEPS)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_word  (u_in),
        .o_out_word (u_out),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // Predictor state: the gain register and the three running averages.
    logic [tfrp_pkg::GAIN_W-1:0] gain_copy;
    int                avg_x;
    int                avg_y;
    int                avg_z;

    // Result words predicted but not yet seen, oldest first.
    t_tilt_word        tilt_pending [$];

    int                fails          = 0;
    int                send_idle_pct  = 0;
    int                recv_stall_pct = 0;
    int                hold_left      = 0;

    // Elementary rotation angles atan(2^-i) in Q30.
    longint            elem_angle [24] = '{
        'h3243F6A8, 'h1DAC6705, 'h0FADBAFC, 'h07F56EA6, 'h03FEAB76, 'h01FFD55B,
        'h00FFFAAA, 'h007FFF55, 'h003FFFEA, 'h001FFFFD, 'h000FFFFF, 'h0007FFFF,
        'h0003FFFF, 'h0001FFFF, 'h0000FFFF, 'h00007FFF, 'h00003FFF, 'h00001FFF,
        'h00000FFF, 'h000007FF, 'h000003FF, 'h000001FF, 'h000000FF, 'h0000007F
    };

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // One step of the moving average; the division truncates toward zero.
    function automatic int smooth_axis(int s, int avg);
        longint num;
        num = longint'(s) * longint'(gain_copy)
            + longint'(avg) * (longint'(GAIN_ONE) - longint'(gain_copy));
        return int'(num / GAIN_ONE);
    endfunction

    // Vectoring rotation giving atan2(yv, xv) in Q30, range (-pi, pi].
    // The axis directions and the zero vector are exact and skip the rotation.
    function automatic longint cordic_angle(longint yv, longint xv);
        longint off;
        longint acc;
        longint xr;
        longint yr;
        longint xs;
        longint ys;
        off = 0;
        acc = 0;
        xr  = xv;
        yr  = yv;
        if (yr == 0) begin
            return (xr < 0) ? PI_ANG : 64'sd0;
        end
        if (xr == 0) begin
            return (yr > 0) ? HALF_PI_ANG : -HALF_PI_ANG;
        end
        // The left half plane is folded onto the right one with an offset of pi.
        if (xr < 0) begin
            off = (yr > 0) ? PI_ANG : -PI_ANG;
            xr  = -xr;
            yr  = -yr;
        end
        xr = xr * VEC_SCALE;
        yr = yr * VEC_SCALE;
        for (int i = 0; i < STEPS && i < 24; i++) begin
            xs = xr >>> i;
            ys = yr >>> i;
            if (yr > 0) begin
                xr  = xr + ys;
                yr  = yr - xs;
                acc = acc + elem_angle[i];
            end else begin
                xr  = xr - ys;
                yr  = yr + xs;
                acc = acc - elem_angle[i];
            end
        end
        return acc + off;
    endfunction

    function automatic longint unsigned floor_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned probe;
        longint unsigned rem;
        res   = 0;
        rem   = v;
        probe = 64'd1 << 62;
        while (probe > rem) probe = probe >> 2;
        while (probe != 0) begin
            if (rem >= res + probe) begin
                rem = rem - (res + probe);
                res = (res >> 1) + probe;
            end else begin
                res = res >> 1;
            end
            probe = probe >> 2;
        end
        return res;
    endfunction

    // Q30 angle rounded half up to the output fraction width.
    function automatic longint to_fixed(longint a);
        return (a + (64'sd1 <<< (29 - FRAC))) >>> (30 - FRAC);
    endfunction

    // Update the averages with one accepted word and queue the result word.
    task automatic tilt_predict(logic [tfrp_pkg::SAMPLE_W-1:0] rx,
                                logic [tfrp_pkg::SAMPLE_W-1:0] ry,
                                logic [tfrp_pkg::SAMPLE_W-1:0] rz);
        longint          x;
        longint          y;
        longint          z;
        longint          ang_roll;
        longint          ang_pitch;
        longint          q;
        longint unsigned mag;
        t_tilt_word      w;
        avg_x = smooth_axis(int'(rx) - CENTRE, avg_x);
        avg_y = smooth_axis(int'(ry) - CENTRE, avg_y);
        avg_z = smooth_axis(int'(rz) - CENTRE, avg_z);
        x = longint'(avg_x);
        y = longint'(avg_y);
        z = longint'(avg_z);

        // Roll is remapped piecewise: the upper left quadrant, pi included,
        // goes to pi/2 - a, every other non-zero angle to 3pi/2 + a. Anything
        // then left just below zero is mirrored to positive.
        ang_roll = cordic_angle(-y, x);
        if (ang_roll >= HALF_PI_ANG && ang_roll <= PI_ANG) begin
            ang_roll = HALF_PI_ANG - ang_roll;
        end else if (ang_roll != 0) begin
            ang_roll = 3 * HALF_PI_ANG + ang_roll;
        end
        if (ang_roll > -HALF_PI_ANG && ang_roll < 0) begin
            ang_roll = -ang_roll;
        end

        // The horizontal magnitude comes out in Q8, so z is brought to Q8 too.
        mag       = floor_sqrt((unsigned'(x * x) + unsigned'(y * y)) << 16);
        ang_pitch = cordic_angle(z * 256, longint'(mag));

        q       = to_fixed(ang_roll);
        w.roll  = q[tfrp_pkg::ROLL_W-1:0];
        q       = to_fixed(ang_pitch);
        w.pitch = q[tfrp_pkg::PITCH_W-1:0];
        w.sx    = avg_x[tfrp_pkg::AVG_W-1:0];
        w.sy    = avg_y[tfrp_pkg::AVG_W-1:0];
        w.sz    = avg_z[tfrp_pkg::AVG_W-1:0];
        tilt_pending.push_back(w);
    endtask

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    function automatic void check_field(string name, logic signed [31:0] want,
                                        logic signed [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fails++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_tilt_word w;
        if (i_rst_n && u_out.valid && u_out.ready) begin
            if (tilt_pending.size() == 0) begin
                $error("result word with no prediction waiting");
                fails++;
            end else begin
                w = tilt_pending.pop_front();
                check_field("roll_angle",  w.roll,  u_out.roll_angle);
                check_field("pitch_angle", w.pitch, u_out.pitch_angle);
                check_field("smoothed_x",  w.sx,    u_out.smoothed_x);
                check_field("smoothed_y",  w.sy,    u_out.smoothed_y);
                check_field("smoothed_z",  w.sz,    u_out.smoothed_z);
            end
        end
    end

    // Receiver: random stalls, or a long hold-off counted down here.
    initial begin
        u_out.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                u_out.ready <= 1'b0;
                hold_left--;
            end else begin
                u_out.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // The run is ended if no word moves on either channel for too long.
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((u_in.valid && u_in.ready) || (u_out.valid && u_out.ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("TB_ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    task automatic set_idling(t_idle_mode mode);
        case (mode)
            IDLE_NONE: begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            IDLE_SENDER: begin
                send_idle_pct  = 69;
                recv_stall_pct = 0;
            end
            IDLE_RECEIVER: begin
                send_idle_pct  = 0;
                recv_stall_pct = 69;
            end
            default: begin
                send_idle_pct  = 36;
                recv_stall_pct = 36;
            end
        endcase
    endtask

    // Offer one sample word and wait until it is taken. Valid stays high on
    // return, so back-to-back words need no gap.
    task automatic send_word(logic [tfrp_pkg::SAMPLE_W-1:0] sx,
                             logic [tfrp_pkg::SAMPLE_W-1:0] sy,
                             logic [tfrp_pkg::SAMPLE_W-1:0] sz);
        @(negedge i_clk);
        if ($urandom_range(99) < send_idle_pct) begin
            u_in.valid <= 1'b0;
            do @(negedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        u_in.valid    <= 1'b1;
        u_in.sample_x <= sx;
        u_in.sample_y <= sy;
        u_in.sample_z <= sz;
        do @(posedge i_clk); while (!u_in.ready);
        tilt_predict(sx, sy, sz);
    endtask

    task automatic halt_input();
        @(negedge i_clk);
        u_in.valid <= 1'b0;
    endtask

    // Wait until every predicted word has arrived and the block has settled.
    task automatic wait_drained();
        while (tilt_pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(logic [tfrp_pkg::PADDR_W-1:0] addr, logic [31:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (addr == tfrp_pkg::ADDR_FILTER_GAIN) begin
            gain_copy = data[tfrp_pkg::GAIN_W-1:0];
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apb_read(logic [tfrp_pkg::PADDR_W-1:0] addr, output logic [31:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        paddr   <= addr;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        data = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic int clamp_raw(int v);
        if (v < 0) return 0;
        if (v > RAW_MAX) return RAW_MAX;
        return v;
    endfunction

    // Random words in bursts around a held tilt, so that the averages have
    // time to settle on it. Some bursts are pure noise.
    task automatic run_bursts(int n_words);
        int                            sent;
        int                            burst;
        int                            spread;
        int                            tgt [3];
        logic [tfrp_pkg::SAMPLE_W-1:0] s [3];
        sent = 0;
        while (sent < n_words) begin
            for (int k = 0; k < 3; k++) begin
                case ($urandom_range(9))
                    0:       tgt[k] = 0;
                    1:       tgt[k] = RAW_MAX;
                    2:       tgt[k] = CENTRE;
                    default: tgt[k] = $urandom_range(RAW_MAX);
                endcase
            end
            case ($urandom_range(3))
                0:       spread = 0;
                1:       spread = 16;
                2:       spread = 512;
                default: spread = RAW_MAX + 1;
            endcase
            burst = $urandom_range(1, 12);
            for (int b = 0; b < burst && sent < n_words; b++) begin
                for (int k = 0; k < 3; k++) begin
                    s[k] = tfrp_pkg::SAMPLE_W'(clamp_raw(tgt[k]
                           + int'($urandom_range(2 * spread)) - spread));
                end
                send_word(s[0], s[1], s[2]);
                sent++;
            end
        end
        halt_input();
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // The gain register reads back its reset value and every value written.
    task automatic test_gain_register();
        logic [31:0]                 rd;
        logic [tfrp_pkg::GAIN_W-1:0] vals [5];
        vals = '{16'h0001, 16'hFFFF, 16'hA5A5, 16'h5A5A, 16'h0000};
        vals[4] = tfrp_pkg::GAIN_W'($urandom_range(1, 65535));
        apb_read(tfrp_pkg::ADDR_FILTER_GAIN, rd);
        check_field("filter_gain", gain_copy, rd[tfrp_pkg::GAIN_W-1:0]);
        foreach (vals[i]) begin
            apb_write(tfrp_pkg::ADDR_FILTER_GAIN, {16'($urandom_range(65535)), vals[i]});
            apb_read(tfrp_pkg::ADDR_FILTER_GAIN, rd);
            check_field("filter_gain", vals[i], rd[tfrp_pkg::GAIN_W-1:0]);
        end
    endtask

    // Directed words at the largest gain, so that the averages follow the
    // samples closely: the zero vector, both axis directions of roll, roll at
    // exactly pi, pitch straight up and down, all corners and near-zero values.
    task automatic test_directed();
        int list [20][3];
        list = '{
            '{CENTRE, CENTRE, CENTRE},
            '{RAW_MAX, CENTRE, CENTRE},
            '{0, CENTRE, CENTRE},
            '{CENTRE, 0, CENTRE},
            '{CENTRE, RAW_MAX, CENTRE},
            '{CENTRE, CENTRE, 0},
            '{CENTRE, CENTRE, RAW_MAX},
            '{0, 0, 0},
            '{0, 0, RAW_MAX},
            '{0, RAW_MAX, 0},
            '{0, RAW_MAX, RAW_MAX},
            '{RAW_MAX, 0, 0},
            '{RAW_MAX, 0, RAW_MAX},
            '{RAW_MAX, RAW_MAX, 0},
            '{RAW_MAX, RAW_MAX, RAW_MAX},
            '{CENTRE + 1, CENTRE, CENTRE},
            '{CENTRE, CENTRE - 1, CENTRE},
            '{CENTRE - 1, CENTRE + 1, CENTRE + 1},
            '{12000, 4000, 9000},
            '{3000, 12000, 5000}
        };
        set_idling(IDLE_NONE);
        apb_write(tfrp_pkg::ADDR_FILTER_GAIN, 32'h0000_FFFF);
        foreach (list[i]) begin
            send_word(tfrp_pkg::SAMPLE_W'(list[i][0]), tfrp_pkg::SAMPLE_W'(list[i][1]),
                      tfrp_pkg::SAMPLE_W'(list[i][2]));
        end
        halt_input();
        wait_drained();
    endtask

    // A gain of zero must leave the averages where they are.
    task automatic test_zero_gain();
        set_idling(IDLE_BOTH);
        apb_write(tfrp_pkg::ADDR_FILTER_GAIN, 32'h0000_0000);
        run_bursts(6);
        wait_drained();
    endtask

    // The receiver holds off for a long stretch while words keep coming, so
    // the block fills up and has to stall its input.
    task automatic test_backpressure();
        set_idling(IDLE_NONE);
        apb_write(tfrp_pkg::ADDR_FILTER_GAIN, 32'h0000_8000);
        @(posedge i_clk);
        hold_left = LONG_HOLD;
        run_bursts(10);
        wait_drained();
    endtask

    // Random phases through every idling pattern and several gains, the
    // extremes among them. The sender pauses until all results are in before
    // each change of gain.
    task automatic test_random_phases();
        logic [tfrp_pkg::GAIN_W-1:0] g;
        for (int p = 0; p < 8; p++) begin
            case (p)
                0, 6:    g = 16'hFFFF;
                1:       g = 16'h8000;
                3:       g = 16'h0001;
                4:       g = tfrp_pkg::GAIN_RESET;
                default: g = tfrp_pkg::GAIN_W'($urandom_range(1, 65535));
            endcase
            set_idling(t_idle_mode'(p % 4));
            apb_write(tfrp_pkg::ADDR_FILTER_GAIN, {16'h0000, g});
            run_bursts(112);
            wait_drained();
        end
    endtask

    initial begin
        u_in.valid    = 1'b0;
        u_in.sample_x = '0;
        u_in.sample_y = '0;
        u_in.sample_z = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        i_rst_n       = 1'b0;
        gain_copy     = tfrp_pkg::GAIN_RESET;
        avg_x         = 0;
        avg_y         = 0;
        avg_z         = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_gain_register();
        test_directed();
        test_zero_gain();
        test_backpressure();
        test_random_phases();

        wait_drained();
        if (fails == 0 && tilt_pending.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

### filelist.f
hdl/tfrp_pkg.sv
hdl/tfrp_if.sv
hdl/tfrp_mul.sv
hdl/tfrp_sqrt.sv
hdl/tfrp_cordic.sv
hdl/tilt_filter_roll_pitch_core.sv
test/tb.sv
